>>> sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the pressure compensation block
// Holds the calibration register set, its register indexes and the datapath
// widths used by the register file, the split multiplier and the top level.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Register indexes, byte address is four times the index.
  typedef enum logic [2:0] {
    IDX_SENS_BASE        = 3'd0,
    IDX_OFFSET_BASE      = 3'd1,
    IDX_SENS_TEMP_COEF   = 3'd2,
    IDX_OFFSET_TEMP_COEF = 3'd3,
    IDX_REF_TEMP_READING = 3'd4,
    IDX_TEMP_GAIN_COEF   = 3'd5,
    IDX_PRESSURE_TRIM    = 3'd6,
    IDX_CURVE_AND_SHIFT  = 3'd7
  } reg_idx_t;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Calibration coefficients as seen by the datapath.
  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] offset_base;
    logic [15:0] sens_temp_coef;
    logic [15:0] offset_temp_coef;
    logic [15:0] ref_temp_reading;
    logic [15:0] temp_gain_coef;
    logic [15:0] pressure_trim;
    logic [23:0] curve_and_shift;
  } cfg_t;

  // Datapath widths. The temperature difference term needs 44 signed bits;
  // a 17-bit coefficient times it needs 61.
  localparam int COEF_W   = 17;
  localparam int DUT_W    = 44;
  localparam int DUT_LO_W = 22;
  localparam int PROD_W   = COEF_W + DUT_W;

  // Clock cycles from an accepted item to its result strobe.
  localparam int LAT = 16;

endpackage

>>> sv/bpc_regs.sv
// ----------------------------------------------------------------------------
// bpc_regs: calibration register file
// APB-style slave holding the eight calibration registers. Writes complete in
// the access phase; reads return the addressed register with no wait states.
// ----------------------------------------------------------------------------
module bpc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bpc_pkg::cfg_t              cfg
);
  import bpc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        IDX_SENS_BASE:        cfg_nxt.sens_base        = pwdata[15:0];
        IDX_OFFSET_BASE:      cfg_nxt.offset_base      = pwdata[15:0];
        IDX_SENS_TEMP_COEF:   cfg_nxt.sens_temp_coef   = pwdata[15:0];
        IDX_OFFSET_TEMP_COEF: cfg_nxt.offset_temp_coef = pwdata[15:0];
        IDX_REF_TEMP_READING: cfg_nxt.ref_temp_reading = pwdata[15:0];
        IDX_TEMP_GAIN_COEF:   cfg_nxt.temp_gain_coef   = pwdata[15:0];
        IDX_PRESSURE_TRIM:    cfg_nxt.pressure_trim    = pwdata[15:0];
        IDX_CURVE_AND_SHIFT:  cfg_nxt.curve_and_shift  = pwdata[23:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      IDX_SENS_BASE:        prdata = {16'd0, cfg_r.sens_base};
      IDX_OFFSET_BASE:      prdata = {16'd0, cfg_r.offset_base};
      IDX_SENS_TEMP_COEF:   prdata = {16'd0, cfg_r.sens_temp_coef};
      IDX_OFFSET_TEMP_COEF: prdata = {16'd0, cfg_r.offset_temp_coef};
      IDX_REF_TEMP_READING: prdata = {16'd0, cfg_r.ref_temp_reading};
      IDX_TEMP_GAIN_COEF:   prdata = {16'd0, cfg_r.temp_gain_coef};
      IDX_PRESSURE_TRIM:    prdata = {16'd0, cfg_r.pressure_trim};
      IDX_CURVE_AND_SHIFT:  prdata = {8'd0, cfg_r.curve_and_shift};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/bpc_dut_mul.sv
// ----------------------------------------------------------------------------
// bpc_dut_mul: coefficient times temperature difference, two stages
// The 44-bit operand is split into a signed upper and an unsigned lower half.
// Two narrow partial products are registered, then summed in the next stage.
// ----------------------------------------------------------------------------
module bpc_dut_mul (
  input  logic                              clk,
  input  logic signed [bpc_pkg::COEF_W-1:0] coef,
  input  logic signed [bpc_pkg::DUT_W-1:0]  dut,
  output logic signed [bpc_pkg::PROD_W-1:0] prod
);
  import bpc_pkg::*;

  localparam int HI_W = DUT_W - DUT_LO_W;

  logic signed [HI_W-1:0]            dut_hi;
  logic signed [DUT_LO_W:0]          dut_lo;
  logic signed [COEF_W+HI_W-1:0]     ph_nxt, ph_r;
  logic signed [COEF_W+DUT_LO_W:0]   pl_nxt, pl_r;
  logic signed [PROD_W-1:0]          prod_nxt, prod_r;

  assign dut_hi = dut[DUT_W-1:DUT_LO_W];
  assign dut_lo = $signed({1'b0, dut[DUT_LO_W-1:0]});
  assign ph_nxt = coef * dut_hi;
  assign pl_nxt = coef * dut_lo;

  // The upper partial product carries the weight 2^22; the exact sum fits.
  assign prod_nxt = $signed({ph_r, {DUT_LO_W{1'b0}}})
                  + $signed({{(PROD_W-COEF_W-DUT_LO_W-1){pl_r[COEF_W+DUT_LO_W]}}, pl_r});
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    ph_r   <= ph_nxt;
    pl_r   <= pl_nxt;
    prod_r <= prod_nxt;
  end

endmodule

>>> sv/barometer_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometer_pressure_compensation: pressure and temperature compensation
// Turns a raw pressure and raw temperature reading into a compensated
// pressure and temperature, in tenths of hPa and tenths of degC with four
// fractional bits, using calibration coefficients held in registers.
// ----------------------------------------------------------------------------
//
//  Channel       Handshake                    Payload
//  ------------  ---------------------------  ---------------------------------
//  input item    start high, busy low         in_pressure_raw, in_temperature_raw
//  result item   out_valid, one cycle only    out_pressure_out, out_temperature_out
//  calibration   psel, penable, pwrite        paddr, pwdata, prdata, pready
//
//  The datapath is a sixteen-stage pipeline and takes one item in every clock
//  cycle; busy is always low. The depth of the pipeline is set chiefly by the
//  two split multiplications (temperature terms and the final sensitivity
//  product). Reset is synchronous and active low; it clears the valid bits
//  of the pipeline and all calibration registers. The receiver cannot stall,
//  so no item is ever held back and nothing needs to be buffered.
//
//  Sensitivity, temperature and trimmed pressure are signed fixed point with
//  sixteen fractional bits. Every division by a power of two rounds toward
//  zero, by adding 2^k-1 to a negative value before the arithmetic shift.
//
module barometer_pressure_compensation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [15:0]                in_pressure_raw,
  input  logic [15:0]                in_temperature_raw,
  output logic                       out_valid,
  output logic signed [18:0]         out_pressure_out,
  output logic signed [15:0]         out_temperature_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bpc_pkg::*;

  cfg_t cfg;

  bpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Fields of the curve register: weights A and B, shifts C and D. Both
  // shifts are four-bit fields and can therefore never exceed 15.
  logic [7:0] w_a, w_b;
  logic [3:0] shift_c, shift_d;

  assign w_a     = cfg.curve_and_shift[7:0];
  assign w_b     = cfg.curve_and_shift[15:8];
  assign shift_c = cfg.curve_and_shift[19:16];
  assign shift_d = cfg.curve_and_shift[23:20];

  // Coefficients in signed form for the multipliers. The offset coefficient
  // has 1024 taken off, so it can go slightly negative.
  logic signed [COEF_W-1:0] k_off, k_sens, k_temp;

  assign k_off  = $signed({1'b0, cfg.offset_temp_coef}) - $signed(17'd1024);
  assign k_sens = $signed({1'b0, cfg.sens_temp_coef});
  assign k_temp = $signed({1'b0, cfg.temp_gain_coef});

  // The pipeline never refuses an item.
  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Valid bit of each stage; bit 0 belongs to stage 1.
  logic [LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[LAT-2:0], accept};

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  logic signed [16:0]        s1_e_r, s1_e_nxt;        // D2 - C5
  logic [7:0]                s1_w_r, s1_w_nxt;        // selected curve weight
  logic signed [16:0]        s1_d1m_nxt;              // D1 - 7168
  logic signed [16:0]        s2_e_r;
  logic [7:0]                s2_w_r;
  logic [31:0]               s2_ee_r, s2_ee_nxt;      // e squared
  logic signed [16:0]        s3_e_r;
  logic [39:0]               s3_eew_r, s3_eew_nxt;    // e squared times weight
  logic signed [DUT_W-1:0]   s4_dut_r, s4_dut_nxt;    // dUT
  logic signed [DUT_W-1:0]   dq_bias;
  logic signed [DUT_W-1:0]   dq_sum;
  logic signed [DUT_W-1:0]   s5_dq_r, s5_dq_nxt;      // dUT / 2^D
  logic signed [DUT_W-1:0]   s6_dq_r, s7_dq_r;
  logic signed [PROD_W-1:0]  off_prod, sens_prod, temp_prod;
  logic signed [PROD_W-1:0]  offq_sum, sensq_sum, tq_sum;
  logic signed [46:0]        s7_offq_r, s7_offq_nxt;
  logic signed [50:0]        s7_sensq_r, s7_sensq_nxt;
  logic signed [44:0]        s7_tq_r, s7_tq_nxt;
  logic signed [47:0]        off_sum;
  logic signed [49:0]        s8_off_nxt;              // offset, OFF
  logic signed [50:0]        s8_sens_r, s8_sens_nxt;  // sensitivity, SENS
  logic signed [46:0]        s8_t_r, s8_t_nxt;        // temperature, Q16
  logic signed [50:0]        sens_abs;
  logic signed [16:0]        d1m_s8;
  logic signed [16:0]        d1m_abs;
  logic [49:0]               s9_ma_r, s9_ma_nxt;
  logic [15:0]               s9_mb_r, s9_mb_nxt;
  logic                      s9_neg_nxt;
  logic signed [46:0]        t_sum;
  logic signed [34:0]        t_q;
  logic signed [15:0]        s9_tout_nxt;
  logic [40:0]               s10_pph_r, s10_pph_nxt;
  logic [40:0]               s10_ppl_r, s10_ppl_nxt;
  logic [63:0]               mag_prod;
  logic [49:0]               s11_m_r, s11_m_nxt;
  logic signed [50:0]        s12_sm_r, s12_sm_nxt;
  logic signed [51:0]        s13_x_r, s13_x_nxt;
  logic signed [55:0]        x_ext;
  logic signed [55:0]        s14_x10_r, s14_x10_nxt;
  logic signed [55:0]        x10_sum;
  logic signed [51:0]        s15_p_r, s15_p_nxt;
  logic signed [51:0]        p_sum;
  logic signed [39:0]        p_q;
  logic signed [18:0]        s16_pout_r, s16_pout_nxt;

  // Delay lines carrying values past the stages that do not use them.
  logic signed [16:0] d1m_pipe_r  [8];   // stages 1 to 8
  logic signed [49:0] off_pipe_r  [5];   // stages 8 to 12
  logic               neg_pipe_r  [3];   // stages 9 to 11
  logic signed [15:0] tout_pipe_r [8];   // stages 9 to 16

  // --------------------------------------------------------------------------
  // Stages 1 to 4: temperature difference with its square-law correction
  // --------------------------------------------------------------------------
  always_comb begin
    s1_e_nxt   = $signed({1'b0, in_temperature_raw}) - $signed({1'b0, cfg.ref_temp_reading});
    // Weight A serves readings at or above the reference, B those below.
    s1_w_nxt   = (in_temperature_raw >= cfg.ref_temp_reading) ? w_a : w_b;
    s1_d1m_nxt = $signed({1'b0, in_pressure_raw}) - $signed(17'd7168);

    s2_ee_nxt  = 32'(s1_e_r * s1_e_r);
    s3_eew_nxt = s2_ee_r * s2_w_r;

    // The correction is never negative, so dUT lies at or below e * 2^16.
    s4_dut_nxt = ($signed({{(DUT_W-17){s3_e_r[16]}}, s3_e_r}) <<< 16)
               - $signed({2'b00, ({s3_eew_r, 2'b00} >> shift_c)});
  end

  // --------------------------------------------------------------------------
  // Stages 5 and 6: the three coefficient products of dUT
  // --------------------------------------------------------------------------
  bpc_dut_mul u_mul_off (
    .clk  (clk),
    .coef (k_off),
    .dut  (s4_dut_r),
    .prod (off_prod)
  );

  bpc_dut_mul u_mul_sens (
    .clk  (clk),
    .coef (k_sens),
    .dut  (s4_dut_r),
    .prod (sens_prod)
  );

  bpc_dut_mul u_mul_temp (
    .clk  (clk),
    .coef (k_temp),
    .dut  (s4_dut_r),
    .prod (temp_prod)
  );

  // dUT scaled by 2^-D travels alongside the products.
  always_comb begin
    dq_bias   = s4_dut_r[DUT_W-1]
              ? $signed((DUT_W'(1) << shift_d) - DUT_W'(1)) : '0;
    dq_sum    = s4_dut_r + dq_bias;
    s5_dq_nxt = dq_sum >>> shift_d;
  end

  // --------------------------------------------------------------------------
  // Stage 7: scale the products, stage 8: offset, sensitivity, temperature
  // --------------------------------------------------------------------------
  always_comb begin
    offq_sum     = off_prod  + (off_prod[PROD_W-1]  ? PROD_W'(16'h3FFF) : '0);
    sensq_sum    = sens_prod + (sens_prod[PROD_W-1] ? PROD_W'(16'h03FF) : '0);
    tq_sum       = temp_prod + (temp_prod[PROD_W-1] ? PROD_W'(16'hFFFF) : '0);
    s7_offq_nxt  = offq_sum[PROD_W-1:14];
    s7_sensq_nxt = sensq_sum[PROD_W-1:10];
    s7_tq_nxt    = tq_sum[PROD_W-1:16];

    off_sum      = $signed({16'd0, cfg.offset_base, 16'd0})
                 + $signed({s7_offq_r[46], s7_offq_r});
    s8_off_nxt   = {off_sum, 2'b00};
    s8_sens_nxt  = $signed({19'd0, cfg.sens_base, 16'd0}) + s7_sensq_r;
    s8_t_nxt     = $signed(47'(32'd250 << 16))
                 + $signed({{2{s7_tq_r[44]}}, s7_tq_r})
                 - $signed({{3{s7_dq_r[DUT_W-1]}}, s7_dq_r});
  end

  // --------------------------------------------------------------------------
  // Stage 9: sign and magnitude of the pressure product, temperature result
  // --------------------------------------------------------------------------
  always_comb begin
    d1m_s8      = d1m_pipe_r[7];
    sens_abs    = s8_sens_r[50] ? -s8_sens_r : s8_sens_r;
    d1m_abs     = d1m_s8[16] ? -d1m_s8 : d1m_s8;
    s9_ma_nxt   = sens_abs[49:0];
    s9_mb_nxt   = d1m_abs[15:0];
    s9_neg_nxt  = s8_sens_r[50] ^ d1m_s8[16];

    t_sum       = s8_t_r + (s8_t_r[46] ? 47'sd4095 : 47'sd0);
    t_q         = t_sum[46:12];
    if (t_q > 35'sd32767) begin
      s9_tout_nxt = 16'sh7FFF;
    end else if (t_q < -35'sd32768) begin
      s9_tout_nxt = 16'sh8000;
    end else begin
      s9_tout_nxt = t_q[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 10 to 13: SENS * (D1 - 7168) / 2^14 on magnitudes, then minus OFF
  // --------------------------------------------------------------------------
  always_comb begin
    s10_pph_nxt = s9_ma_r[49:25] * s9_mb_r;
    s10_ppl_nxt = s9_ma_r[24:0]  * s9_mb_r;
    // The exact product stays below 2^64, so the upper bits can be dropped.
    mag_prod    = {s10_pph_r[38:0], 25'd0} + {23'd0, s10_ppl_r};
    s11_m_nxt   = mag_prod[63:14];
    s12_sm_nxt  = neg_pipe_r[2] ? -$signed({1'b0, s11_m_r}) : $signed({1'b0, s11_m_r});
    s13_x_nxt   = $signed({s12_sm_r[50], s12_sm_r})
                - $signed({{2{off_pipe_r[4][49]}}, off_pipe_r[4]});
  end

  // --------------------------------------------------------------------------
  // Stages 14 to 16: times ten, over 32, trim, over 4096 and saturate
  // --------------------------------------------------------------------------
  always_comb begin
    x_ext       = $signed({{4{s13_x_r[51]}}, s13_x_r});
    s14_x10_nxt = (x_ext <<< 3) + (x_ext <<< 1);

    x10_sum     = s14_x10_r + (s14_x10_r[55] ? 56'sd31 : 56'sd0);
    s15_p_nxt   = $signed({x10_sum[55], x10_sum[55:5]})
                + $signed({20'd0, cfg.pressure_trim, 16'd0});

    p_sum       = s15_p_r + (s15_p_r[51] ? 52'sd4095 : 52'sd0);
    p_q         = p_sum[51:12];
    if (p_q > 40'sd262143) begin
      s16_pout_nxt = 19'sh3FFFF;
    end else if (p_q < -40'sd262144) begin
      s16_pout_nxt = 19'sh40000;
    end else begin
      s16_pout_nxt = p_q[18:0];
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload registers load every cycle; the valid bits say which stages hold
  // an item.
  always_ff @(posedge clk) begin
    s1_e_r     <= s1_e_nxt;
    s1_w_r     <= s1_w_nxt;
    s2_e_r     <= s1_e_r;
    s2_w_r     <= s1_w_r;
    s2_ee_r    <= s2_ee_nxt;
    s3_e_r     <= s2_e_r;
    s3_eew_r   <= s3_eew_nxt;
    s4_dut_r   <= s4_dut_nxt;
    s5_dq_r    <= s5_dq_nxt;
    s6_dq_r    <= s5_dq_r;
    s7_dq_r    <= s6_dq_r;
    s7_offq_r  <= s7_offq_nxt;
    s7_sensq_r <= s7_sensq_nxt;
    s7_tq_r    <= s7_tq_nxt;
    s8_sens_r  <= s8_sens_nxt;
    s8_t_r     <= s8_t_nxt;
    s9_ma_r    <= s9_ma_nxt;
    s9_mb_r    <= s9_mb_nxt;
    s10_pph_r  <= s10_pph_nxt;
    s10_ppl_r  <= s10_ppl_nxt;
    s11_m_r    <= s11_m_nxt;
    s12_sm_r   <= s12_sm_nxt;
    s13_x_r    <= s13_x_nxt;
    s14_x10_r  <= s14_x10_nxt;
    s15_p_r    <= s15_p_nxt;
    s16_pout_r <= s16_pout_nxt;

    d1m_pipe_r[0]  <= s1_d1m_nxt;
    for (int i = 1; i < 8; i++) begin
      d1m_pipe_r[i]  <= d1m_pipe_r[i-1];
      tout_pipe_r[i] <= tout_pipe_r[i-1];
    end
    tout_pipe_r[0] <= s9_tout_nxt;
    off_pipe_r[0]  <= s8_off_nxt;
    for (int i = 1; i < 5; i++) begin
      off_pipe_r[i] <= off_pipe_r[i-1];
    end
    neg_pipe_r[0]  <= s9_neg_nxt;
    for (int i = 1; i < 3; i++) begin
      neg_pipe_r[i] <= neg_pipe_r[i-1];
    end
  end

  assign out_valid           = vld_r[LAT-1];
  assign out_pressure_out    = s16_pout_r;
  assign out_temperature_out = tout_pipe_r[7];

`ifndef SYNTH
  // Every result strobe goes back to an item accepted at the head of the
  // pipeline.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted item");

  // The signed quotient of the pressure product takes the sign worked out
  // from SENS and D1 - 7168 unless it is zero.
  a_product_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[11] && s12_sm_r != '0) |-> (s12_sm_r[50] == $past(neg_pipe_r[2])))
    else $error("pressure product sign does not follow its operands");

  // A 16-bit register reads back what was written to it.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(psel && penable && pwrite) && psel && !pwrite
     && paddr == $past(paddr)
     && $past(paddr[ADDR_W-1:2]) != IDX_CURVE_AND_SHIFT)
    |-> (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("calibration register does not read back its written value");
`endif

endmodule
